@@ hw/rtl/mtdc_pkg.sv @@
// Shared types and constants for the multi-hit TDC data word decoder.
package mtdc_pkg;

    // Field widths
    localparam int WORD_W   = 32;
    localparam int WTYPE_W  = 5;
    localparam int CHAN_W   = 5;
    localparam int TIME_W   = 21;
    localparam int IDX_W    = 4;
    localparam int KIND_W   = 3;
    localparam int MAXH_W   = 4;

    // Bit positions inside the readout word
    localparam int WTYPE_LSB = 27;
    localparam int EDGE_BIT  = 26;
    localparam int CHAN_LSB  = 21;

    // Stream payload widths
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = KIND_W;
    localparam int M_PAD_W   = M_TDATA_W - (1 + 1 + CHAN_W + 1 + IDX_W + TIME_W);

    // APB register map
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam logic REG_MAX_HITS = 1'b0;
    localparam logic [MAXH_W-1:0] MAX_HITS_RST = 4'd10;

    // Word type codes
    localparam logic [WTYPE_W-1:0] WT_MEAS    = 5'd0;
    localparam logic [WTYPE_W-1:0] WT_THEADER = 5'd1;
    localparam logic [WTYPE_W-1:0] WT_GHEADER = 5'd8;
    localparam logic [WTYPE_W-1:0] WT_TRAILER = 5'd16;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_IN,
        PH_CLOSED
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_MEAS    = 3'd0,
        KIND_GHEADER = 3'd1,
        KIND_THEADER = 3'd2,
        KIND_TRAILER = 3'd3,
        KIND_OTHER   = 3'd4,
        KIND_OUTSIDE = 3'd5
    } kind_t;

    // Counter update from the classifier to the counter store
    typedef struct packed {
        logic             we;
        logic             clear;
        logic [IDX_W-1:0] value;
    } cnt_upd_t;

    // One decoded result
    typedef struct packed {
        kind_t             kind;
        logic              hit_counted;
        logic              hit_stored;
        logic [CHAN_W-1:0] hit_channel;
        logic              hit_edge;
        logic [IDX_W-1:0]  hit_index;
        logic [TIME_W-1:0] hit_time;
        logic              event_done;
    } result_t;

endpackage

@@ hw/rtl/mtdc_apb_regs.sv @@
// APB configuration register block holding the max_hits limit.
module mtdc_apb_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mtdc_pkg::APB_AW-1:0]       paddr,
    input  logic [mtdc_pkg::APB_DW-1:0]       pwdata,
    output logic [mtdc_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    output logic [mtdc_pkg::MAXH_W-1:0]       max_hits
);

    logic [mtdc_pkg::MAXH_W-1:0] max_hits_reg;
    logic [mtdc_pkg::MAXH_W-1:0] max_hits_next;
    logic                        reg_sel;
    logic                        wr_en;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[mtdc_pkg::APB_AW-1:2] == mtdc_pkg::REG_MAX_HITS);
    assign wr_en   = psel && penable && pwrite && pready;

    // Register write
    always_comb begin
        max_hits_next = max_hits_reg;
        if (wr_en && reg_sel) begin
            max_hits_next = pwdata[mtdc_pkg::MAXH_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_hits_reg <= mtdc_pkg::MAX_HITS_RST;
        end else begin
            max_hits_reg <= max_hits_next;
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (reg_sel) begin
            prdata = {{(mtdc_pkg::APB_DW - mtdc_pkg::MAXH_W){1'b0}}, max_hits_reg};
        end
    end

    assign max_hits = max_hits_reg;

endmodule

@@ hw/rtl/mtdc_hit_counters.sv @@
// Per channel and edge hit counters: memory, valid bits and write bypass.
module mtdc_hit_counters #(
    parameter int CHANNELS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            rd_en,
    input  logic [$clog2(2*CHANNELS)-1:0]   rd_slot,
    input  logic [$clog2(2*CHANNELS)-1:0]   cur_slot,
    input  mtdc_pkg::cnt_upd_t              upd,
    output logic [mtdc_pkg::IDX_W-1:0]      count
);

    localparam int AW    = $clog2(2*CHANNELS);
    localparam int DEPTH = 1 << AW;

    logic [mtdc_pkg::IDX_W-1:0] mem [DEPTH];
    logic [mtdc_pkg::IDX_W-1:0] rd_data_reg;
    logic [DEPTH-1:0]           vld_reg;
    logic [DEPTH-1:0]           vld_next;
    logic                       byp_vld_reg;
    logic [AW-1:0]              byp_slot_reg;
    logic [mtdc_pkg::IDX_W-1:0] byp_val_reg;

    // Counter memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (upd.we) begin
            mem[cur_slot] <= upd.value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_slot];
        end
    end

    // Valid bits: an entry not written since the last clear reads as zero
    always_comb begin
        vld_next = vld_reg;
        if (upd.clear) begin
            vld_next = '0;
        end
        if (upd.we) begin
            vld_next[cur_slot] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Bypass of the latest write, covers a read taken on the same edge
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_vld_reg <= 1'b0;
        end else if (upd.we) begin
            byp_vld_reg <= 1'b1;
        end else if (upd.clear) begin
            byp_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd.we) begin
            byp_slot_reg <= cur_slot;
            byp_val_reg  <= upd.value;
        end
    end

    always_comb begin
        if (byp_vld_reg && (byp_slot_reg == cur_slot)) begin
            count = byp_val_reg;
        end else if (vld_reg[cur_slot]) begin
            count = rd_data_reg;
        end else begin
            count = '0;
        end
    end

endmodule

@@ hw/rtl/mtdc_classify.sv @@
// Word classifier: event phase tracking and hit acceptance.
module mtdc_classify #(
    parameter int CHANNELS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            proc,
    input  logic [mtdc_pkg::WORD_W-1:0]     word,
    input  logic                            event_start,
    input  logic [mtdc_pkg::MAXH_W-1:0]     max_hits,
    input  logic [mtdc_pkg::IDX_W-1:0]      count,
    output logic [$clog2(2*CHANNELS)-1:0]   cur_slot,
    output mtdc_pkg::cnt_upd_t              upd,
    output mtdc_pkg::result_t               res
);

    localparam int AW = $clog2(2*CHANNELS);
    localparam int CW = AW - 1;

    mtdc_pkg::phase_t                phase_reg;
    mtdc_pkg::phase_t                phase_next;
    mtdc_pkg::phase_t                phase_eff;
    mtdc_pkg::phase_t                phase_step;
    logic [mtdc_pkg::WTYPE_W-1:0]    wtype;
    logic [mtdc_pkg::CHAN_W-1:0]     chan;
    logic                            edge_bit;
    logic [mtdc_pkg::TIME_W-1:0]     tval;
    logic                            in_range;
    logic [mtdc_pkg::IDX_W-1:0]      cnt_eff;

    // Field extraction
    assign wtype    = word[mtdc_pkg::WTYPE_LSB +: mtdc_pkg::WTYPE_W];
    assign chan     = word[mtdc_pkg::CHAN_LSB +: mtdc_pkg::CHAN_W];
    assign edge_bit = word[mtdc_pkg::EDGE_BIT];
    assign tval     = word[mtdc_pkg::TIME_W-1:0];
    assign cur_slot = {chan[CW-1:0], edge_bit};
    assign in_range = ({1'b0, chan} < (mtdc_pkg::CHAN_W + 1)'(CHANNELS));

    // event_start clears the counters and restarts the header wait first
    assign phase_eff = event_start ? mtdc_pkg::PH_WAIT : phase_reg;
    assign cnt_eff   = event_start ? '0 : count;

    // Next phase
    always_comb begin
        phase_step = phase_eff;
        unique case (phase_eff)
            mtdc_pkg::PH_WAIT: begin
                if (wtype == mtdc_pkg::WT_GHEADER) begin
                    phase_step = mtdc_pkg::PH_IN;
                end
            end
            mtdc_pkg::PH_IN: begin
                if (wtype == mtdc_pkg::WT_TRAILER) begin
                    phase_step = mtdc_pkg::PH_CLOSED;
                end
            end
            mtdc_pkg::PH_CLOSED: begin
                phase_step = mtdc_pkg::PH_CLOSED;
            end
            default: begin
                phase_step = mtdc_pkg::PH_WAIT;
            end
        endcase
        phase_next = proc ? phase_step : phase_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= mtdc_pkg::PH_WAIT;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // Result and counter update
    always_comb begin
        res       = '0;
        res.kind  = mtdc_pkg::KIND_OUTSIDE;
        upd.we    = 1'b0;
        upd.clear = proc && event_start;
        upd.value = cnt_eff + 1'b1;
        unique case (phase_eff)
            mtdc_pkg::PH_WAIT: begin
                if (wtype == mtdc_pkg::WT_GHEADER) begin
                    res.kind = mtdc_pkg::KIND_GHEADER;
                end
            end
            mtdc_pkg::PH_IN: begin
                unique case (wtype)
                    mtdc_pkg::WT_MEAS: begin
                        res.kind        = mtdc_pkg::KIND_MEAS;
                        res.hit_channel = chan;
                        res.hit_edge    = edge_bit;
                        res.hit_time    = tval;
                        if (in_range) begin
                            res.hit_index = cnt_eff;
                            if (cnt_eff < max_hits) begin
                                res.hit_counted = 1'b1;
                                res.hit_stored  = (tval != '0);
                                upd.we          = proc;
                            end
                        end
                    end
                    mtdc_pkg::WT_THEADER: begin
                        res.kind = mtdc_pkg::KIND_THEADER;
                    end
                    mtdc_pkg::WT_TRAILER: begin
                        res.kind       = mtdc_pkg::KIND_TRAILER;
                        res.event_done = 1'b1;
                    end
                    default: begin
                        res.kind = mtdc_pkg::KIND_OTHER;
                    end
                endcase
            end
            default: begin
                res.kind = mtdc_pkg::KIND_OUTSIDE;
            end
        endcase
    end

endmodule

@@ hw/rtl/multihit_tdc_word_decoder_top.sv @@
// Top level of the multi-hit TDC data word decoder.
//
//  port group | dir | payload                                   | handshake
//  s_*        | in  | tdata: data_word; tuser: event_start      | tvalid/tready
//  m_*        | out | tdata: hit fields; tuser: word_kind;      | tvalid/tready
//             |     | tlast: event_done                         |
//  APB        | in  | max_hits at byte address 0                | psel/penable
//
// One word per clock while the result stream is not stalled. A word passes the
// input register (with the registered counter memory read), then the result register.
// The counter read-modify-write is the critical loop; a one-entry bypass
// keeps it at one word per cycle. aresetn is synchronous: it empties both
// registers, returns to the header wait and invalidates all counters.
// A stalled result holds while a new word may still enter the input register.
module multihit_tdc_word_decoder_top #(
    parameter int CHANNELS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mtdc_pkg::WORD_W-1:0]         s_tdata,   // [31:0] data_word
    input  logic                                s_tuser,   // [0] event_start
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] hit_counted, [1] hit_stored, [6:2] hit_channel, [7] hit_edge,
    // [11:8] hit_index, [32:12] hit_time, [39:33] zero
    output logic [mtdc_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [mtdc_pkg::M_TUSER_W-1:0]      m_tuser,   // [2:0] word_kind
    output logic                                m_tlast,   // event_done
    // Configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mtdc_pkg::APB_AW-1:0]         paddr,
    input  logic [mtdc_pkg::APB_DW-1:0]         pwdata,
    output logic [mtdc_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    localparam int AW = $clog2(2*CHANNELS);
    localparam int CW = AW - 1;

    logic                               in_vld_reg;
    logic                               in_vld_next;
    logic [mtdc_pkg::WORD_W-1:0]        word_reg;
    logic                               evs_reg;
    logic                               m_vld_reg;
    logic                               m_vld_next;
    logic [mtdc_pkg::M_TDATA_W-1:0]     m_data_reg;
    logic [mtdc_pkg::M_TUSER_W-1:0]     m_user_reg;
    logic                               m_last_reg;
    logic                               adv;
    logic                               proc;
    logic                               acc;
    logic [AW-1:0]                      rd_slot;
    logic [AW-1:0]                      cur_slot;
    logic [mtdc_pkg::MAXH_W-1:0]        max_hits;
    logic [mtdc_pkg::IDX_W-1:0]         count;
    mtdc_pkg::cnt_upd_t                 upd;
    mtdc_pkg::result_t                  res;

    // Handshake
    assign adv      = !m_vld_reg || m_tready;
    assign proc     = in_vld_reg && adv;
    assign s_tready = !in_vld_reg || adv;
    assign acc      = s_tvalid && s_tready;
    assign rd_slot  = {s_tdata[mtdc_pkg::CHAN_LSB +: CW], s_tdata[mtdc_pkg::EDGE_BIT]};

    // Input register
    always_comb begin
        in_vld_next = in_vld_reg;
        if (acc) begin
            in_vld_next = 1'b1;
        end else if (proc) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            word_reg <= s_tdata;
            evs_reg  <= s_tuser;
        end
    end

    mtdc_apb_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .max_hits (max_hits)
    );

    mtdc_hit_counters #(
        .CHANNELS (CHANNELS)
    ) u_cnt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (acc),
        .rd_slot  (rd_slot),
        .cur_slot (cur_slot),
        .upd      (upd),
        .count    (count)
    );

    mtdc_classify #(
        .CHANNELS (CHANNELS)
    ) u_cls (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .proc        (proc),
        .word        (word_reg),
        .event_start (evs_reg),
        .max_hits    (max_hits),
        .count       (count),
        .cur_slot    (cur_slot),
        .upd         (upd),
        .res         (res)
    );

    // Result register
    always_comb begin
        m_vld_next = m_vld_reg;
        if (proc) begin
            m_vld_next = 1'b1;
        end else if (m_tready) begin
            m_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else begin
            m_vld_reg <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            m_data_reg <= {{mtdc_pkg::M_PAD_W{1'b0}}, res.hit_time, res.hit_index,
                           res.hit_edge, res.hit_channel, res.hit_stored,
                           res.hit_counted};
            m_user_reg <= res.kind;
            m_last_reg <= res.event_done;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

@@ hw/rtl/mtdc_checker.sv @@
// Port-level checker for the decoder result stream, bound to the top level.
module mtdc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [mtdc_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [mtdc_pkg::M_TUSER_W-1:0]   m_tuser,
    input logic                             m_tlast
);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Event close is flagged only on trailer transactions
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == mtdc_pkg::KIND_TRAILER)))
        else $error("tlast does not match trailer kind");

    // Stored hits are always counted hits
    a_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[0])
        else $error("hit stored without being counted");

    // Hit fields are zero for anything but a measurement
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != mtdc_pkg::KIND_MEAS) |-> (m_tdata == '0))
        else $error("hit fields set on a non-measurement word");

endmodule

bind multihit_tdc_word_decoder_top mtdc_checker u_mtdc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ tb/sv/multihit_tdc_word_decoder_top_test.sv @@
// Stream testbench for the multi-hit TDC data word decoder, with its own decoding predictor.
module multihit_tdc_word_decoder_top_test;

    localparam int TDC_CHANNELS   = 32;
    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int MAX_IDLE       = 13;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int PHASE_WORDS    = 24;
    localparam int NUM_PHASES     = 10;
    localparam longint RUN_LIMIT  = 64'd400000 * 2 * CLK_HALF;
    localparam logic [mtdc_pkg::APB_AW-1:0] MAX_HITS_ADDR =
        mtdc_pkg::APB_AW'(4 * mtdc_pkg::REG_MAX_HITS);

    typedef struct {
        logic [mtdc_pkg::WORD_W-1:0] word;
        logic                        start;
    } readout_word_t;

    // Clock, reset and DUT ports
    logic                              aclk;
    logic                              aresetn  = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [mtdc_pkg::WORD_W-1:0]       s_tdata  = '0;    // [31:0] data_word
    logic                              s_tuser  = 1'b0;  // [0] event_start
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    // [0] hit_counted, [1] hit_stored, [6:2] hit_channel, [7] hit_edge,
    // [11:8] hit_index, [32:12] hit_time, [39:33] zero
    logic [mtdc_pkg::M_TDATA_W-1:0]    m_tdata;
    logic [mtdc_pkg::M_TUSER_W-1:0]    m_tuser;          // [2:0] word_kind
    logic                              m_tlast;
    logic                              psel     = 1'b0;
    logic                              penable  = 1'b0;
    logic                              pwrite   = 1'b0;
    logic [mtdc_pkg::APB_AW-1:0]       paddr    = '0;
    logic [mtdc_pkg::APB_DW-1:0]       pwdata   = '0;
    logic [mtdc_pkg::APB_DW-1:0]       prdata;
    logic                              pready;

    // Words waiting to be sent and decoded results still owed by the block
    readout_word_t       pending_words[$];
    mtdc_pkg::result_t   expected_results[$];
    int                  words_queued = 0;
    int                  error_count  = 0;

    // Idling control
    int   tx_wait      = 0;
    int   rx_wait      = 0;
    bit   tx_no_idle   = 1'b0;
    bit   rx_no_idle   = 1'b0;
    bit   rx_hold_req  = 1'b0;
    bit   rx_hold_ack  = 1'b0;
    int   rx_hold_left = 0;

    // Predictor state
    mtdc_pkg::phase_t                  phase_model = mtdc_pkg::PH_WAIT;
    logic [mtdc_pkg::IDX_W-1:0]        hit_count_model [2*TDC_CHANNELS];
    logic [mtdc_pkg::MAXH_W-1:0]       max_hits_model = mtdc_pkg::MAX_HITS_RST;

    multihit_tdc_word_decoder_top #(
        .CHANNELS (TDC_CHANNELS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    initial begin
        foreach (hit_count_model[i]) hit_count_model[i] = '0;
    end

    // Decode one accepted word against the predictor state
    function automatic mtdc_pkg::result_t decode_expected(
            input logic [mtdc_pkg::WORD_W-1:0] word, input logic start);
        mtdc_pkg::result_t             r;
        logic [mtdc_pkg::WTYPE_W-1:0]  wtype;
        logic [mtdc_pkg::CHAN_W-1:0]   chan;
        logic                          trail;
        int                            slot;
        r     = '0;
        wtype = word[mtdc_pkg::WORD_W-1:mtdc_pkg::WTYPE_LSB];
        chan  = word[mtdc_pkg::CHAN_LSB +: mtdc_pkg::CHAN_W];
        trail = word[mtdc_pkg::EDGE_BIT];
        if (start) begin
            foreach (hit_count_model[i]) hit_count_model[i] = '0;
            phase_model = mtdc_pkg::PH_WAIT;
        end
        case (phase_model)
            mtdc_pkg::PH_WAIT: begin
                if (wtype == mtdc_pkg::WT_GHEADER) begin
                    r.kind      = mtdc_pkg::KIND_GHEADER;
                    phase_model = mtdc_pkg::PH_IN;
                end else begin
                    r.kind = mtdc_pkg::KIND_OUTSIDE;
                end
            end
            mtdc_pkg::PH_IN: begin
                if (wtype == mtdc_pkg::WT_MEAS) begin
                    r.kind        = mtdc_pkg::KIND_MEAS;
                    r.hit_channel = chan;
                    r.hit_edge    = trail;
                    r.hit_time    = word[mtdc_pkg::TIME_W-1:0];
                    // channels beyond the instance are reported but never counted
                    if (chan < TDC_CHANNELS) begin
                        slot        = 2 * chan + trail;
                        r.hit_index = hit_count_model[slot];
                        if (hit_count_model[slot] < max_hits_model) begin
                            hit_count_model[slot] = hit_count_model[slot] + 1'b1;
                            r.hit_counted         = 1'b1;
                            r.hit_stored          = (r.hit_time != '0);
                        end
                    end
                end else if (wtype == mtdc_pkg::WT_THEADER) begin
                    r.kind = mtdc_pkg::KIND_THEADER;
                end else if (wtype == mtdc_pkg::WT_TRAILER) begin
                    r.kind       = mtdc_pkg::KIND_TRAILER;
                    r.event_done = 1'b1;
                    phase_model  = mtdc_pkg::PH_CLOSED;
                end else begin
                    r.kind = mtdc_pkg::KIND_OTHER;
                end
            end
            default: r.kind = mtdc_pkg::KIND_OUTSIDE;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic check_field(input string what, input longint got, input longint want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    // Compare the transaction on the result port with the oldest expectation
    task automatic check_decoded();
        mtdc_pkg::result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected result transaction", m_tdata, 0);
            return;
        end
        want = expected_results.pop_front();
        check_field("word_kind",   m_tuser,        want.kind);
        check_field("hit_counted", m_tdata[0],     want.hit_counted);
        check_field("hit_stored",  m_tdata[1],     want.hit_stored);
        check_field("hit_channel", m_tdata[6:2],   want.hit_channel);
        check_field("hit_edge",    m_tdata[7],     want.hit_edge);
        check_field("hit_index",   m_tdata[11:8],  want.hit_index);
        check_field("hit_time",    m_tdata[32:12], want.hit_time);
        check_field("event_done",  m_tlast,        want.event_done);
    endtask

    // Sender: offers queued words with a random gap after each
    always @(posedge aclk) begin : tx_side
        readout_word_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_wait  <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.insert(expected_results.size(),
                                        decode_expected(s_tdata, s_tuser));
            if (!s_tvalid || s_tready) begin
                if (tx_wait != 0) begin
                    tx_wait  <= tx_wait - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    item     = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= item.word;
                    s_tuser  <= item.start;
                    tx_wait  <= tx_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here and kicked by toggling rx_hold_req
    always @(posedge aclk) begin
        if (rx_hold_req != rx_hold_ack) begin
            rx_hold_left <= RX_HOLD_CYCLES;
            rx_hold_ack  <= rx_hold_req;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // Receiver: checks each result transaction, then stalls a random while
    always @(posedge aclk) begin : rx_side
        int wait_n;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_decoded();
                wait_n = rx_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            end else begin
                wait_n = (rx_wait != 0) ? rx_wait - 1 : 0;
            end
            rx_wait  <= wait_n;
            m_tready <= (wait_n == 0) && (rx_hold_left == 0);
        end
    end

    // Stimulus helpers
    function automatic logic [mtdc_pkg::WORD_W-1:0] meas_word(
            input logic [mtdc_pkg::CHAN_W-1:0] chan,
            input logic trail,
            input logic [mtdc_pkg::TIME_W-1:0] tval);
        return {mtdc_pkg::WT_MEAS, trail, chan, tval};
    endfunction

    task automatic push_word(input logic [mtdc_pkg::WORD_W-1:0] word, input logic start);
        readout_word_t item;
        item.word  = word;
        item.start = start;
        pending_words.insert(pending_words.size(), item);
        words_queued++;
    endtask

    // One random event: header, a body of mixed words, trailer, maybe stray words
    task automatic queue_event(input int body_len, input int chan_span);
        int                            pick;
        logic [mtdc_pkg::WTYPE_W-1:0]  wt;
        logic [mtdc_pkg::TIME_W-1:0]   tval;
        logic                          trail;
        push_word({mtdc_pkg::WT_GHEADER, 27'($urandom)}, $urandom_range(0, 7) != 0);
        for (int k = 0; k < body_len; k++) begin
            pick = $urandom_range(0, 19);
            if (pick < 15) begin
                tval  = ($urandom_range(0, 7) == 0) ? '0 : mtdc_pkg::TIME_W'($urandom);
                // narrow spans lean on one edge so the hit limit is reached
                trail = (chan_span <= 3) ? ($urandom_range(0, 3) == 0) : 1'($urandom);
                push_word(meas_word(mtdc_pkg::CHAN_W'($urandom_range(0, chan_span - 1)),
                                    trail, tval),
                          1'b0);
            end else if (pick == 15) begin
                push_word({mtdc_pkg::WT_THEADER, 27'($urandom)}, 1'b0);
            end else if (pick == 16) begin
                wt = mtdc_pkg::WTYPE_W'($urandom_range(2, 31));
                if (wt == mtdc_pkg::WT_GHEADER || wt == mtdc_pkg::WT_TRAILER) wt = wt + 1'b1;
                push_word({wt, 27'($urandom)}, 1'b0);
            end else if (pick == 17) begin
                push_word({mtdc_pkg::WT_GHEADER, 27'($urandom)}, 1'b0);
            end else if (pick == 18) begin
                push_word($urandom, 1'b0);
            end else begin
                push_word($urandom, 1'b1);
            end
        end
        push_word({mtdc_pkg::WT_TRAILER, 27'($urandom)}, 1'b0);
        repeat ($urandom_range(0, 2)) push_word($urandom, 1'b0);
    endtask

    // Waits until every queued word is sent and every result has come back
    task automatic wait_drained();
        while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // APB write: setup then access cycle
    task automatic write_max_hits(input logic [mtdc_pkg::MAXH_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_HITS_ADDR;
        pwdata  <= mtdc_pkg::APB_DW'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        max_hits_model = value;
        @(negedge aclk);
    endtask

    // Main sequence
    initial begin : stimulus
        logic [mtdc_pkg::MAXH_W-1:0] cfg_seq [NUM_PHASES];
        int                          phase_start;
        int                          span;
        cfg_seq = '{4'd1, 4'd15, 4'd3, 4'd7, 4'd2, 4'd12, 4'd5, 4'd15, 4'd1, 4'd9};

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed words with the reset value of max_hits (ten)
        push_word(meas_word(5'd0, 1'b0, 21'h1FFFFF), 1'b0);   // before any header
        push_word({mtdc_pkg::WT_GHEADER, 27'h7FFFFFF}, 1'b0);
        push_word(meas_word(5'd31, 1'b1, 21'h1FFFFF), 1'b0);
        push_word({mtdc_pkg::WT_GHEADER, 27'd0}, 1'b0);       // header inside event
        push_word(meas_word(5'd31, 1'b1, 21'd0), 1'b0);       // counted, zero time
        push_word({mtdc_pkg::WT_THEADER, 27'h5A5A5A5}, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);                       // unknown type
        for (int k = 0; k < 11; k++)                          // last one over the limit
            push_word(meas_word(5'd5, 1'b0, mtdc_pkg::TIME_W'((k + 1) * 'h12345)), 1'b0);
        push_word({mtdc_pkg::WT_TRAILER, 27'h7FFFFFF}, 1'b0);
        push_word(meas_word(5'd1, 1'b0, 21'd7), 1'b0);        // event closed
        push_word({mtdc_pkg::WT_GHEADER, 27'd1}, 1'b0);       // closed: header ignored
        push_word({mtdc_pkg::WT_GHEADER, 27'd2}, 1'b1);       // restart clears counters
        push_word(meas_word(5'd5, 1'b0, 21'd9), 1'b0);
        push_word({mtdc_pkg::WT_TRAILER, 27'd0}, 1'b0);
        push_word(32'd0, 1'b1);                               // restart on a non-header
        wait_drained();

        // Random phases, one max_hits setting each
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_max_hits(cfg_seq[ph]);
            tx_no_idle  = (ph % 3 == 1);
            rx_no_idle  = (ph % 3 == 2);
            span        = (ph % 2 == 1) ? $urandom_range(1, 3) : TDC_CHANNELS;
            phase_start = words_queued;
            if (ph == 4) begin
                // receiver holds off while the sender keeps offering
                rx_hold_req = !rx_hold_req;
                tx_no_idle  = 1'b1;
            end
            repeat ($urandom_range(0, 3)) push_word($urandom, 1'($urandom));
            while (words_queued - phase_start < PHASE_WORDS / 2)
                queue_event($urandom_range(1, 40), span);
            if (ph == 6) wait_drained();
            while (words_queued - phase_start < PHASE_WORDS)
                queue_event($urandom_range(1, 40), span);
            wait_drained();
        end

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Run limit
    initial begin
        #(RUN_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ multihit_tdc_word_decoder_top.f @@
hw/rtl/mtdc_pkg.sv
hw/rtl/mtdc_apb_regs.sv
hw/rtl/mtdc_hit_counters.sv
hw/rtl/mtdc_classify.sv
hw/rtl/multihit_tdc_word_decoder_top.sv
hw/rtl/mtdc_checker.sv
tb/sv/multihit_tdc_word_decoder_top_test.sv
